// ===== rtl/core/itoa_pkg.sv =====
// Package with payload types, cell control, state codes and ASCII helpers.
`timescale 1ns / 1ps
`default_nettype none

package itoa_pkg;

    localparam int VALUE_BITS_DEF = 64;
    localparam int MAX_WIDTH_DEF  = 32;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_A     = 8'h61;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    typedef struct packed {
        logic        action;
        logic [63:0] value;
        logic [5:0]  width;
    } t_in;

    typedef struct packed {
        logic [7:0] char_out;
        logic       last;
    } t_out;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_BIT,
        CELL_DIGIT
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     hex;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_NORM,
        ST_PAD,
        ST_SIGN,
        ST_DIGITS
    } t_state;

    function automatic logic [7:0] digit_to_ascii(input logic [3:0] d);
        logic [7:0] c;
        if (d <= 4'd9) begin
            c = CHAR_ZERO + {4'd0, d};
        end else begin
            c = CHAR_A + {4'd0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/itoa_cell.sv =====
// One digit cell: shift-and-correct step for decimal, plain shift for hex, digit move.
`timescale 1ns / 1ps
`default_nettype none

module itoa_cell
    import itoa_pkg::*;
(
    input  wire logic       i_clk,
    input  t_cell_ctl       i_ctl,
    input  wire logic       i_bit,
    input  wire logic [3:0] i_digit,
    output logic            o_bit,
    output logic [3:0]      o_digit
);

    logic [3:0] r_digit;
    logic [3:0] n_digit;
    logic [3:0] corr;

    always_comb begin
        if (!i_ctl.hex && (r_digit >= 4'd5)) begin
            corr = r_digit + 4'd3;
        end else begin
            corr = r_digit;
        end
        case (i_ctl.op)
            CELL_CLEAR: n_digit = 4'd0;
            CELL_BIT:   n_digit = {corr[2:0], i_bit};
            CELL_DIGIT: n_digit = i_digit;
            default:    n_digit = r_digit;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

    assign o_bit   = corr[3];
    assign o_digit = r_digit;

endmodule

`default_nettype wire

// ===== rtl/core/itoa_chain.sv =====
// Row of digit cells; the least significant cell takes the serial bit.
`timescale 1ns / 1ps
`default_nettype none

module itoa_chain
    import itoa_pkg::*;
#(
    parameter int N_CELLS = 20
) (
    input  wire logic       i_clk,
    input  t_cell_ctl       i_ctl,
    input  wire logic       i_bit,
    output logic [3:0]      o_top_digit
);

    logic [N_CELLS:0]   bits;
    logic [3:0]         digits [N_CELLS+1];

    assign bits[0]   = i_bit;
    assign digits[0] = 4'd0;

    for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
        itoa_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (i_ctl),
            .i_bit   (bits[k]),
            .i_digit (digits[k]),
            .o_bit   (bits[k+1]),
            .o_digit (digits[k+1])
        );
    end

    assign o_top_digit = digits[N_CELLS];

endmodule

`default_nettype wire

// ===== rtl/core/integer_to_ascii_padded.sv =====
// Top level: integer to padded ASCII text, one character per output transfer.
// Steps: one input transfer, then shifting the VALUE_BITS magnitude bits through the
// digit cells, then dropping up to (digit cells - 1) leading zeros, then sizing the
// padding, then one character per cycle while the output does not stall.
// One item is worked at a time; the input stalls outside the idle state.
// Reset (synchronous, active low) returns to idle and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_ascii_padded
    import itoa_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  t_in       i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_out      o_out_data
);

    localparam int N_CELLS = ((VALUE_BITS * 1233) >> 12) + 1;
    localparam int NDW     = $clog2(N_CELLS + 1);
    localparam int CNTW    = $clog2(VALUE_BITS);
    localparam int PW      = $clog2(MAX_WIDTH + 1);
    localparam int LW      = (PW > 6 ? PW : 6) + 1;

    t_state                r_state, n_state;
    logic [VALUE_BITS-1:0] r_mag, n_mag;
    logic                  r_hex, n_hex;
    logic                  r_neg, n_neg;
    logic [5:0]            r_width, n_width;
    logic [CNTW-1:0]       r_cnt, n_cnt;
    logic [NDW-1:0]        r_nd, n_nd;
    logic [PW-1:0]         r_pad, n_pad;
    logic                  r_out_valid, n_out_valid;
    t_out                  r_out, n_out;

    t_cell_ctl             cell_ctl;
    logic [3:0]            top_digit;
    logic                  advance;
    logic [VALUE_BITS-1:0] in_val;
    logic                  in_neg;
    logic [LW-1:0]         w_ext, w_sat, t_len, pad_full;

    itoa_chain #(
        .N_CELLS (N_CELLS)
    ) u_chain (
        .i_clk       (i_clk),
        .i_ctl       (cell_ctl),
        .i_bit       (r_mag[VALUE_BITS-1]),
        .o_top_digit (top_digit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_mag   <= n_mag;
        r_hex   <= n_hex;
        r_neg   <= n_neg;
        r_width <= n_width;
        r_cnt   <= n_cnt;
        r_nd    <= n_nd;
        r_pad   <= n_pad;
        r_out   <= n_out;
    end

    always_comb begin
        in_val = i_in_data.value[VALUE_BITS-1:0];
        in_neg = !i_in_data.action && in_val[VALUE_BITS-1];

        w_ext = {{(LW-6){1'b0}}, r_width};
        if (w_ext > LW'(MAX_WIDTH)) begin
            w_sat = LW'(MAX_WIDTH);
        end else begin
            w_sat = w_ext;
        end
        t_len = {{(LW-NDW){1'b0}}, r_nd} + {{(LW-1){1'b0}}, r_neg};
        if (w_sat > t_len) begin
            pad_full = w_sat - t_len;
        end else begin
            pad_full = '0;
        end

        advance = !r_out_valid || !i_out_stall;

        n_state     = r_state;
        n_mag       = r_mag;
        n_hex       = r_hex;
        n_neg       = r_neg;
        n_width     = r_width;
        n_cnt       = r_cnt;
        n_nd        = r_nd;
        n_pad       = r_pad;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        cell_ctl.op  = CELL_HOLD;
        cell_ctl.hex = r_hex;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_hex   = i_in_data.action;
                    n_neg   = in_neg;
                    n_width = i_in_data.width;
                    n_mag   = in_neg ? (~in_val + 1'b1) : in_val;
                    n_cnt   = CNTW'(VALUE_BITS - 1);
                    cell_ctl.op = CELL_CLEAR;
                    n_state = ST_CONVERT;
                end
            end
            ST_CONVERT: begin
                cell_ctl.op = CELL_BIT;
                n_mag = {r_mag[VALUE_BITS-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                n_nd  = NDW'(N_CELLS);
                if (r_cnt == '0) begin
                    n_state = ST_NORM;
                end
            end
            ST_NORM: begin
                if ((top_digit == 4'd0) && (r_nd > NDW'(1))) begin
                    cell_ctl.op = CELL_DIGIT;
                    n_nd = r_nd - 1'b1;
                end else begin
                    n_pad = pad_full[PW-1:0];
                    if (pad_full != '0) begin
                        n_state = ST_PAD;
                    end else if (r_neg) begin
                        n_state = ST_SIGN;
                    end else begin
                        n_state = ST_DIGITS;
                    end
                end
            end
            ST_PAD: begin
                if (advance) begin
                    n_out_valid    = 1'b1;
                    n_out.char_out = r_hex ? CHAR_ZERO : CHAR_SPACE;
                    n_out.last     = 1'b0;
                    n_pad          = r_pad - 1'b1;
                    if (r_pad == PW'(1)) begin
                        n_state = r_neg ? ST_SIGN : ST_DIGITS;
                    end
                end
            end
            ST_SIGN: begin
                if (advance) begin
                    n_out_valid    = 1'b1;
                    n_out.char_out = CHAR_MINUS;
                    n_out.last     = 1'b0;
                    n_state        = ST_DIGITS;
                end
            end
            ST_DIGITS: begin
                if (advance) begin
                    n_out_valid    = 1'b1;
                    n_out.char_out = digit_to_ascii(top_digit);
                    n_out.last     = (r_nd == NDW'(1));
                    cell_ctl.op    = CELL_DIGIT;
                    n_nd           = r_nd - 1'b1;
                    if (r_nd == NDW'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for integer_to_ascii_padded with a character scoreboard.
`timescale 1ns / 1ps

module testbench;
    import itoa_pkg::*;

    localparam logic ACT_DEC = 1'b0;
    localparam logic ACT_HEX = 1'b1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 200;
    localparam int RANDOM_PER_PHASE = 25;

    class ascii_scoreboard;
        t_out expected_chars[$];
        int mismatches = 0;
        int chars_checked = 0;
        int numbers_noted = 0;

        function void note_number(t_in item);
            logic [63:0] mag;
            logic [7:0] rev[0:63];
            logic [3:0] d;
            logic negative;
            int field;
            int base;
            int nd;
            int pad;
            t_out c;
            field = item.width;
            if (field > MAX_WIDTH_DEF) begin
                field = MAX_WIDTH_DEF;
            end
            negative = (item.action == ACT_DEC) && item.value[63];
            mag = negative ? (64'd0 - item.value) : item.value;
            base = (item.action == ACT_HEX) ? 16 : 10;
            nd = 0;
            do begin
                d = 4'(mag % base);
                rev[nd] = (d < 10) ? CHAR_ZERO + 8'(d) : CHAR_A + 8'(d) - 8'd10;
                mag = mag / base;
                nd++;
            end while (mag != 0);
            pad = field - nd - (negative ? 1 : 0);
            c.last = 1'b0;
            for (int i = 0; i < pad; i++) begin
                c.char_out = (item.action == ACT_HEX) ? CHAR_ZERO : CHAR_SPACE;
                expected_chars.push_back(c);
            end
            if (negative) begin
                c.char_out = CHAR_MINUS;
                expected_chars.push_back(c);
            end
            for (int i = nd - 1; i >= 0; i--) begin
                c.char_out = rev[i];
                c.last = (i == 0);
                expected_chars.push_back(c);
            end
            numbers_noted++;
        endfunction

        function void check_char(t_out got);
            t_out exp;
            chars_checked++;
            if (expected_chars.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Unexpected character transfer: %h last %b",
                             got.char_out, got.last);
                end
            end else begin
                exp = expected_chars.pop_front();
                if (got.char_out !== exp.char_out || got.last !== exp.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Mismatch: expected char %h last %b, got char %h last %b",
                                 exp.char_out, exp.last, got.char_out, got.last);
                    end
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    t_in in_data = '0;
    logic out_stall = 1'b0;
    logic in_stall;
    logic out_valid;
    t_out out_data;

    int idle_pct = 0;
    int stall_pct = 0;
    int cycles = 0;
    int directed_count = 0;
    ascii_scoreboard board = new();

    integer_to_ascii_padded dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles.", cycles);
            $display("integer_to_ascii_padded verification failed");
            $finish;
        end
    end

    // Receiver: checks every accepted character and stalls at random.
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall) begin
            board.check_char(out_data);
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic send_number(input t_in item);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge i_clk);
        while (in_stall) begin
            @(posedge i_clk);
        end
        board.note_number(item);
    endtask

    task automatic send_directed(input logic act, input logic [63:0] val,
                                 input logic [5:0] wid);
        t_in item;
        item.action = act;
        item.value = val;
        item.width = wid;
        send_number(item);
        directed_count++;
    endtask

    function automatic t_in make_random_number();
        t_in item;
        item.action = 1'($urandom_range(1));
        case ($urandom_range(4))
            0: item.value = {$urandom, $urandom};
            1: item.value = 64'($urandom_range(9999));
            2: item.value = 64'd0 - 64'($urandom_range(9999));
            3: item.value = $urandom_range(1) ? {1'b1, 63'd0} + 64'($urandom_range(50))
                                              : {1'b0, {63{1'b1}}} - 64'($urandom_range(50));
            default: item.value = {$urandom, $urandom} >> $urandom_range(63);
        endcase
        item.width = ($urandom_range(3) == 0) ? 6'($urandom_range(33, 63))
                                              : 6'($urandom_range(32));
        return item;
    endfunction

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero, all-ones, sign boundaries, width extremes and every hex digit.
        send_directed(ACT_DEC, 64'd0, 6'd0);
        send_directed(ACT_HEX, 64'd0, 6'd0);
        send_directed(ACT_HEX, 64'd0, 6'd32);
        send_directed(ACT_DEC, 64'd0, 6'd63);
        send_directed(ACT_DEC, {64{1'b1}}, 6'd0);
        send_directed(ACT_HEX, {64{1'b1}}, 6'd0);
        send_directed(ACT_HEX, {64{1'b1}}, 6'd32);
        send_directed(ACT_DEC, {1'b1, 63'd0}, 6'd0);
        send_directed(ACT_DEC, {1'b1, 63'd0}, 6'd25);
        send_directed(ACT_HEX, {1'b1, 63'd0}, 6'd33);
        send_directed(ACT_DEC, {1'b0, {63{1'b1}}}, 6'd19);
        send_directed(ACT_DEC, {1'b0, {63{1'b1}}}, 6'd63);
        send_directed(ACT_HEX, 64'h0123456789abcdef, 6'd1);
        send_directed(ACT_HEX, 64'hfedcba9876543210, 6'd16);
        send_directed(ACT_DEC, 64'd0 - 64'd42, 6'd10);
        send_directed(ACT_DEC, 64'd42, 6'd2);
        send_directed(ACT_DEC, 64'd12345, 6'd3);
        send_directed(ACT_DEC, 64'd9, 6'd1);
        send_directed(ACT_DEC, 64'd10, 6'd31);
        send_directed(ACT_HEX, 64'h10, 6'd40);
        send_directed(ACT_DEC, 64'd0 - 64'd1, 6'd2);
        send_directed(ACT_DEC, 64'd1000000000000000000, 6'd20);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 85; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 85; end
                default: begin idle_pct = 31; stall_pct = 31; end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                send_number(make_random_number());
            end
        end
        in_valid <= 1'b0;

        while (board.expected_chars.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Converted %0d numbers (%0d directed) into %0d checked characters,",
                 board.numbers_noted, directed_count, board.chars_checked);
        $display("under free-running, sender-idle, receiver-stall and mixed traffic.");
        if (board.mismatches == 0 && board.expected_chars.size() == 0) begin
            $display("integer_to_ascii_padded verification clean");
        end else begin
            $display("%0d mismatches, %0d characters never arrived.",
                     board.mismatches, board.expected_chars.size());
            $display("integer_to_ascii_padded verification failed");
        end
        $finish;
    end

endmodule
